/* hw/rtl/mds_pkg.sv */
// Shared types, opcodes and control word constants for the MIPS decode stage.
package mds_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);

  // Opcodes
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_J     = 6'h02;
  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_BNE   = 6'h05;
  localparam logic [5:0] OPC_ADDI  = 6'h08;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SW    = 6'h2B;

  // R-type function codes
  localparam logic [5:0] FN_JR  = 6'h08;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_XOR = 6'h26;
  localparam logic [5:0] FN_NOR = 6'h27;

  // Control word bits
  localparam logic [11:0] CW_REGDST   = 12'h001;
  localparam logic [11:0] CW_ALUSRC   = 12'h002;
  localparam logic [11:0] CW_MEMRD    = 12'h004;
  localparam logic [11:0] CW_MEMWR    = 12'h008;
  localparam logic [11:0] CW_MEMTOREG = 12'h010;
  localparam logic [11:0] CW_REGWR    = 12'h020;
  localparam logic [11:0] CW_BRANCH   = 12'h040;
  localparam logic [11:0] CW_BNE      = 12'h080;
  localparam logic [11:0] CW_JUMP     = 12'h100;
  localparam logic [11:0] CW_JR       = 12'h200;
  localparam logic [11:0] CW_ALU_ADD  = 12'h400;
  localparam logic [11:0] CW_ALU_SUB  = 12'h800;
  localparam logic [11:0] CW_ALU_FN   = 12'hC00;

  localparam logic ACT_DECODE = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUBBLE  = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef struct packed {
    logic              action;
    logic              slot_valid;
    logic [31:0]       instruction;
    logic [31:0]       pc_next;
    logic [REG_AW-1:0] write_index;
    logic [XLEN-1:0]   write_data;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [11:0]       control_word;
    logic [REG_AW-1:0] rs_index;
    logic [REG_AW-1:0] rt_index;
    logic [REG_AW-1:0] rd_index;
    logic [5:0]        funct_code;
    logic [XLEN-1:0]   rs_value;
    logic [XLEN-1:0]   rt_value;
    logic [31:0]       imm_extended;
    logic [31:0]       branch_dest;
    logic [31:0]       jump_dest;
    logic [31:0]       pc_next_out;
  } rsp_t;

  // Register file write port
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  // Decoder result
  typedef struct packed {
    status_t     status;
    logic [11:0] control_word;
    logic [31:0] imm_extended;
    logic [31:0] branch_dest;
    logic [31:0] jump_dest;
  } dec_t;

endpackage

/* hw/rtl/mds_regfile.sv */
// Register file: 32 x 32 synchronous memory, two registered read ports, one write port.
module mds_regfile
  import mds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rf_wr_t            wr,
  input  logic              rd_en,
  input  logic [REG_AW-1:0] rs_addr,
  input  logic [REG_AW-1:0] rt_addr,
  output logic [XLEN-1:0]   rs_data,
  output logic [XLEN-1:0]   rt_data
);

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] written;
  logic [XLEN-1:0]      rs_q;
  logic [XLEN-1:0]      rt_q;
  logic                 rs_live;
  logic                 rt_live;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  // Entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rs_q    <= mem[rs_addr];
      rt_q    <= mem[rt_addr];
      rs_live <= written[rs_addr] && (rs_addr != '0);
      rt_live <= written[rt_addr] && (rt_addr != '0);
    end
  end

  assign rs_data = rs_live ? rs_q : '0;
  assign rt_data = rt_live ? rt_q : '0;

endmodule

/* hw/rtl/mds_decode.sv */
// Instruction decoder: control word, immediate, branch and jump targets.
module mds_decode
  import mds_pkg::*;
(
  input  logic        slot_valid,
  input  logic [31:0] instruction,
  input  logic [31:0] pc_next,
  output dec_t        dec
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [11:0] cw;
  logic        legal;
  logic [31:0] imm;

  assign op  = instruction[31:26];
  assign fn  = instruction[5:0];
  assign imm = {{16{instruction[15]}}, instruction[15:0]};

  always_comb begin
    cw    = '0;
    legal = 1'b1;
    unique case (op)
      OPC_RTYPE: begin
        unique case (fn) inside
          FN_JR:                                        cw = CW_JR;
          FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR: cw = CW_REGDST | CW_REGWR | CW_ALU_FN;
          default:                                      legal = 1'b0;
        endcase
      end
      OPC_ADDI: cw = CW_ALUSRC | CW_REGWR | CW_ALU_ADD;
      OPC_LW:   cw = CW_ALUSRC | CW_MEMRD | CW_MEMTOREG | CW_REGWR | CW_ALU_ADD;
      OPC_SW:   cw = CW_ALUSRC | CW_MEMWR | CW_ALU_ADD;
      OPC_BEQ:  cw = CW_BRANCH | CW_ALU_SUB;
      OPC_BNE:  cw = CW_BRANCH | CW_BNE | CW_ALU_SUB;
      OPC_J:    cw = CW_JUMP;
      default:  legal = 1'b0;
    endcase
  end

  always_comb begin
    dec = '0;
    if (!slot_valid) begin
      dec.status = ST_BUBBLE;
    end else if (!legal) begin
      dec.status = ST_ILLEGAL;
    end else begin
      dec.status       = ST_OK;
      dec.control_word = cw;
      dec.imm_extended = imm;
      dec.branch_dest  = pc_next + {imm[29:0], 2'b00};
      dec.jump_dest    = {pc_next[31:28], instruction[25:0], 2'b00};
    end
  end

endmodule

/* hw/rtl/mips_decode_stage_core.sv */
// MIPS decode stage: register file, decoder and two-stage result pipeline.
// Decode request: result passes through the read register and then the output register; a sink stall can hold it.
// Throughput: one request per cycle, decode or write-back, sustained when the sink does not stall.
// Write-back request: stored at the accept edge, visible to a decode accepted the next cycle.
// Reset: synchronous; empties the pipeline and clears the file's written bits.
module mips_decode_stage_core
  import mds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  req_t src_item,
  output logic dst_valid,
  input  logic dst_stall,
  output rsp_t dst_item
);

  logic            src_acc;
  rf_wr_t          rf_wr;
  logic            rd_en;
  logic [XLEN-1:0] rs_data;
  logic [XLEN-1:0] rt_data;
  dec_t            dec;

  logic            s1_valid;
  dec_t            s1_dec;
  logic [31:0]     s1_instr;
  logic [31:0]     s1_pc;
  logic            s2_valid;
  rsp_t            s2_item;
  rsp_t            s2_next;
  logic            s2_load;
  logic            s1_ok;

  assign src_stall = s1_valid && s2_valid && dst_stall;
  assign src_acc   = src_valid && !src_stall;
  assign rd_en     = src_acc && (src_item.action == ACT_DECODE);

  assign rf_wr.en   = src_acc && (src_item.action == ACT_WRITE);
  assign rf_wr.idx  = src_item.write_index;
  assign rf_wr.data = src_item.write_data;

  mds_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr      (rf_wr),
    .rd_en   (rd_en),
    .rs_addr (src_item.instruction[25:21]),
    .rt_addr (src_item.instruction[20:16]),
    .rs_data (rs_data),
    .rt_data (rt_data)
  );

  mds_decode u_decode (
    .slot_valid  (src_item.slot_valid),
    .instruction (src_item.instruction),
    .pc_next     (src_item.pc_next),
    .dec         (dec)
  );

  // Stage 1: decode result alongside the register file read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!src_stall) begin
      s1_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_dec   <= dec;
      s1_instr <= src_item.instruction;
      s1_pc    <= src_item.pc_next;
    end
  end

  assign s1_ok   = (s1_dec.status == ST_OK);
  assign s2_load = !s2_valid || !dst_stall;

  always_comb begin
    s2_next = '0;
    s2_next.status = s1_dec.status;
    if (s1_ok) begin
      s2_next.control_word = s1_dec.control_word;
      s2_next.rs_index     = s1_instr[25:21];
      s2_next.rt_index     = s1_instr[20:16];
      s2_next.rd_index     = s1_instr[15:11];
      s2_next.funct_code   = s1_instr[5:0];
      s2_next.rs_value     = rs_data;
      s2_next.rt_value     = rt_data;
      s2_next.imm_extended = s1_dec.imm_extended;
      s2_next.branch_dest  = s1_dec.branch_dest;
      s2_next.jump_dest    = s1_dec.jump_dest;
      s2_next.pc_next_out  = s1_pc;
    end
  end

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      s2_item <= s2_next;
    end
  end

  assign dst_valid = s2_valid;
  assign dst_item  = s2_item;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !s1_valid && !dst_valid)
    else $error("pipeline not empty after reset");

  a_nonok_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.status != ST_OK |->
      dst_item.control_word == '0 && dst_item.rs_value == '0 &&
      dst_item.rt_value == '0 && dst_item.pc_next_out == '0)
    else $error("bubble or illegal result carries nonzero fields");

  a_r0_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.status == ST_OK && dst_item.rs_index == '0 |->
      dst_item.rs_value == '0)
    else $error("register zero read nonzero");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_valid && dst_stall |=> s1_valid && s2_valid)
    else $error("stalled pipeline lost a request");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for the MIPS decode stage: directed and random requests checked against a predictor.
module testbench;
  import mds_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned RANDOM_REQUESTS = 1100;
  localparam int unsigned RANDOM_CHUNKS   = 8;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned PRINT_CAP       = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  req_t src_item = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  rsp_t dst_item;

  mips_decode_stage_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

  logic [XLEN-1:0] shadow_regs [REG_COUNT];
  rsp_t            expected_decodes [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned writes_sent = 0;
  int unsigned decodes_sent = 0;
  int unsigned bubbles_sent = 0;
  int unsigned illegal_sent = 0;
  int unsigned results_checked = 0;
  bit          src_idle_on = 1'b0;
  bit          dst_idle_on = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly zero, some short, a few long.
  function automatic int unsigned pick_gap(bit enable);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!enable || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("tb: mismatch on %s at result %0d: got %h, expected %h",
               what, results_checked, got, want);
  endtask

  function automatic rsp_t predict_decode(req_t r);
    rsp_t        res;
    logic [11:0] cw;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic        known;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [31:0] imm;
    res = '0;
    if (!r.slot_valid) begin
      res.status = ST_BUBBLE;
      return res;
    end
    op = r.instruction[31:26];
    fn = r.instruction[5:0];
    known = 1'b1;
    cw = '0;
    case (op)
      OPC_RTYPE: begin
        if (fn == FN_JR)
          cw = CW_JR;
        else if (fn == FN_ADD || fn == FN_SUB || fn == FN_AND || fn == FN_OR ||
                 fn == FN_XOR || fn == FN_NOR)
          cw = CW_REGDST | CW_REGWR | CW_ALU_FN;
        else
          known = 1'b0;
      end
      OPC_ADDI: cw = CW_ALUSRC | CW_REGWR | CW_ALU_ADD;
      OPC_LW:   cw = CW_ALUSRC | CW_MEMRD | CW_MEMTOREG | CW_REGWR | CW_ALU_ADD;
      OPC_SW:   cw = CW_ALUSRC | CW_MEMWR | CW_ALU_ADD;
      OPC_BEQ:  cw = CW_BRANCH | CW_ALU_SUB;
      OPC_BNE:  cw = CW_BRANCH | CW_BNE | CW_ALU_SUB;
      OPC_J:    cw = CW_JUMP;
      default:  known = 1'b0;
    endcase
    if (!known) begin
      res.status = ST_ILLEGAL;
      return res;
    end
    rs = r.instruction[25:21];
    rt = r.instruction[20:16];
    imm = {{16{r.instruction[15]}}, r.instruction[15:0]};
    res.status       = ST_OK;
    res.control_word = cw;
    res.rs_index     = rs;
    res.rt_index     = rt;
    res.rd_index     = r.instruction[15:11];
    res.funct_code   = fn;
    res.rs_value     = (rs == '0) ? '0 : shadow_regs[rs];
    res.rt_value     = (rt == '0) ? '0 : shadow_regs[rt];
    res.imm_extended = imm;
    res.branch_dest  = r.pc_next + (imm << 2);
    res.jump_dest    = {r.pc_next[31:28], r.instruction[25:0], 2'b00};
    res.pc_next_out  = r.pc_next;
    return res;
  endfunction

  // Called at the accept edge, so write-backs land in program order.
  function automatic void track_request(req_t r);
    rsp_t want;
    if (r.action == ACT_WRITE) begin
      shadow_regs[r.write_index] = r.write_data;
      writes_sent++;
    end else begin
      want = predict_decode(r);
      expected_decodes.push_back(want);
      decodes_sent++;
      if (want.status == ST_BUBBLE) bubbles_sent++;
      if (want.status == ST_ILLEGAL) illegal_sent++;
    end
  endfunction

  // Entered and left on a falling edge.
  task automatic send_request(input req_t r);
    int unsigned gap;
    logic [127:0] noise;
    src_item <= r;
    src_valid <= 1'b1;
    do @(posedge clk); while (src_stall);
    track_request(r);
    @(negedge clk);
    gap = pick_gap(src_idle_on);
    if (gap != 0) begin
      noise = {$urandom(), $urandom(), $urandom(), $urandom()};
      src_valid <= 1'b0;
      src_item <= noise[$bits(req_t)-1:0];
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic req_t decode_req(logic [31:0] instr, logic [31:0] pc);
    req_t r;
    r.action      = ACT_DECODE;
    r.slot_valid  = 1'b1;
    r.instruction = instr;
    r.pc_next     = pc;
    r.write_index = REG_AW'($urandom());
    r.write_data  = $urandom();
    return r;
  endfunction

  function automatic req_t write_req(logic [4:0] idx, logic [31:0] data);
    req_t r;
    r.action      = ACT_WRITE;
    r.slot_valid  = 1'($urandom());
    r.instruction = $urandom();
    r.pc_next     = $urandom();
    r.write_index = idx;
    r.write_data  = data;
    return r;
  endfunction

  function automatic logic [31:0] encode(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] low);
    return {op, rs, rt, low};
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    int unsigned roll;
    w = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      case ($urandom_range(0, 6))
        0: w[31:26] = OPC_RTYPE;
        1: w[31:26] = OPC_J;
        2: w[31:26] = OPC_BEQ;
        3: w[31:26] = OPC_BNE;
        4: w[31:26] = OPC_ADDI;
        5: w[31:26] = OPC_LW;
        default: w[31:26] = OPC_SW;
      endcase
      if (w[31:26] == OPC_RTYPE) begin
        case ($urandom_range(0, 6))
          0: w[5:0] = FN_JR;
          1: w[5:0] = FN_ADD;
          2: w[5:0] = FN_SUB;
          3: w[5:0] = FN_AND;
          4: w[5:0] = FN_OR;
          5: w[5:0] = FN_XOR;
          default: w[5:0] = FN_NOR;
        endcase
      end
    end else if (roll < 88) begin
      w[31:26] = OPC_RTYPE;   // random funct, mostly unsupported
    end
    return w;
  endfunction

  task automatic test_register_file();
    src_idle_on = 1'b0;
    dst_idle_on = 1'b0;
    send_request(write_req(5'd1, 32'hFFFF_FFFF));
    send_request(write_req(5'd31, 32'h8000_0001));
    send_request(write_req(5'd0, 32'hDEAD_BEEF));    // $zero still reads zero
    send_request(decode_req(encode(OPC_RTYPE, 5'd31, 5'd1, {5'd31, 5'd0, FN_ADD}),
                            32'h0000_0004));
    send_request(decode_req(encode(OPC_RTYPE, 5'd0, 5'd0, {5'd0, 5'd0, FN_ADD}),
                            32'h0000_0008));
    // write then read in the very next cycle
    send_request(write_req(5'd1, 32'h0000_0000));
    send_request(decode_req(encode(OPC_RTYPE, 5'd1, 5'd31, {5'd2, 5'd0, FN_SUB}),
                            32'h0000_000C));
  endtask

  task automatic test_each_operation();
    src_idle_on = 1'b1;
    dst_idle_on = 1'b1;
    send_request(decode_req(encode(OPC_RTYPE, 5'd31, 5'd31, {5'd3, 5'd0, FN_SUB}), 32'h10));
    send_request(decode_req(encode(OPC_RTYPE, 5'd1, 5'd31, {5'd4, 5'd0, FN_AND}), 32'h14));
    send_request(decode_req(encode(OPC_RTYPE, 5'd31, 5'd0, {5'd5, 5'd0, FN_OR}), 32'h18));
    send_request(decode_req(encode(OPC_RTYPE, 5'd31, 5'd1, {5'd6, 5'd0, FN_XOR}), 32'h1C));
    send_request(decode_req(encode(OPC_RTYPE, 5'd0, 5'd31, {5'd7, 5'd31, FN_NOR}), 32'h20));
    send_request(decode_req(encode(OPC_RTYPE, 5'd31, 5'd0, {5'd0, 5'd0, FN_JR}), 32'h24));
    send_request(decode_req(encode(OPC_ADDI, 5'd31, 5'd2, 16'h7FFF), 32'h28));
    send_request(decode_req(encode(OPC_LW, 5'd1, 5'd3, 16'h8000), 32'h2C));
    send_request(decode_req(encode(OPC_SW, 5'd31, 5'd31, 16'hFFFF), 32'h30));
    // branch target wraps past the top of the address space
    send_request(decode_req(encode(OPC_BEQ, 5'd1, 5'd31, 16'h7FFF), 32'hFFFF_FFFC));
    send_request(decode_req(encode(OPC_BNE, 5'd31, 5'd1, 16'h8000), 32'h0000_0000));
    send_request(decode_req({OPC_J, 26'h3FF_FFFF}, 32'hF000_0004));
    send_request(decode_req({OPC_J, 26'h000_0000}, 32'hFFFF_FFFF));
  endtask

  task automatic test_special_cases();
    req_t r;
    src_idle_on = 1'b1;
    dst_idle_on = 1'b0;
    r = decode_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    r.slot_valid = 1'b0;
    send_request(r);
    send_request(decode_req(32'hFFFF_FFFF, 32'h1234_5678));
    send_request(decode_req(encode(OPC_RTYPE, 5'd31, 5'd31, {5'd31, 5'd31, 6'h3F}),
                            32'h8000_0000));
    send_request(decode_req(encode(OPC_RTYPE, 5'd1, 5'd1, {5'd1, 5'd0, 6'h00}), 32'h40));
  endtask

  task automatic test_random_traffic();
    req_t        r;
    int unsigned roll;
    int unsigned chunk;
    int unsigned n;
    logic [31:0] data;
    for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      // walk through every combination of sender and receiver idling
      src_idle_on = chunk[0];
      dst_idle_on = chunk[1];
      for (n = 0; n < RANDOM_REQUESTS / RANDOM_CHUNKS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          data = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom();
          r = write_req(5'($urandom()), data);
        end else begin
          r = decode_req(random_instruction(), $urandom());
          if (roll < 33) r.slot_valid = 1'b0;
        end
        send_request(r);
      end
    end
  endtask

  initial begin : sink_stall
    int unsigned hold;
    forever begin
      @(negedge clk);
      hold = pick_gap(dst_idle_on);
      if (hold != 0) begin
        dst_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        dst_stall <= 1'b0;
      end
    end
  end

  initial begin : result_checker
    rsp_t got;
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && dst_valid && !dst_stall) begin
        got = dst_item;
        if (expected_decodes.size() == 0) begin
          flag_mismatch("result with no request pending", got.pc_next_out, '0);
        end else begin
          want = expected_decodes.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.control_word !== want.control_word)
            flag_mismatch("control_word", 32'(got.control_word), 32'(want.control_word));
          if (got.rs_index !== want.rs_index)
            flag_mismatch("rs_index", 32'(got.rs_index), 32'(want.rs_index));
          if (got.rt_index !== want.rt_index)
            flag_mismatch("rt_index", 32'(got.rt_index), 32'(want.rt_index));
          if (got.rd_index !== want.rd_index)
            flag_mismatch("rd_index", 32'(got.rd_index), 32'(want.rd_index));
          if (got.funct_code !== want.funct_code)
            flag_mismatch("funct_code", 32'(got.funct_code), 32'(want.funct_code));
          if (got.rs_value !== want.rs_value)
            flag_mismatch("rs_value", got.rs_value, want.rs_value);
          if (got.rt_value !== want.rt_value)
            flag_mismatch("rt_value", got.rt_value, want.rt_value);
          if (got.imm_extended !== want.imm_extended)
            flag_mismatch("imm_extended", got.imm_extended, want.imm_extended);
          if (got.branch_dest !== want.branch_dest)
            flag_mismatch("branch_dest", got.branch_dest, want.branch_dest);
          if (got.jump_dest !== want.jump_dest)
            flag_mismatch("jump_dest", got.jump_dest, want.jump_dest);
          if (got.pc_next_out !== want.pc_next_out)
            flag_mismatch("pc_next_out", got.pc_next_out, want.pc_next_out);
        end
        results_checked++;
      end
    end
  end

  initial begin : main_sequence
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_register_file();
    test_each_operation();
    test_special_cases();
    test_random_traffic();
    src_valid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: sent %0d decodes (%0d bubbles, %0d illegal) and %0d write-backs",
             decodes_sent, bubbles_sent, illegal_sent, writes_sent);
    $display("tb: checked %0d results in %0d cycles, %0d mismatches",
             results_checked, cycle_count, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
